### design/ksm_pkg.sv
package ksm_pkg;

   // Register indexes on the csr port
   localparam logic [2:0] REG_KEY_LENGTH  = 3'd0;
   localparam logic [2:0] REG_KEY_CHARS_0 = 3'd1;
   localparam logic [2:0] REG_KEY_CHARS_1 = 3'd2;
   localparam logic [2:0] REG_KEY_CHARS_2 = 3'd3;
   localparam logic [2:0] REG_KEY_CHARS_3 = 3'd4;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;
   localparam int KEY_LEN_BITS   = 5;
   localparam int SLOT_BITS      = 16;   // one key character slot in a key_chars register
   localparam int SLOTS_PER_REG  = 4;
   localparam int KEY_REGS       = 4;
   localparam int FIELD_BITS     = 16;   // span_start / span_length / char_code

   typedef struct packed {
      logic [15:0] char_code;
      logic        char_present;
      logic        line_end;
   } req_word_type;

   typedef struct packed {
      logic [15:0] span_start;
      logic [15:0] span_length;
      logic        span_present;
      logic        last_of_line;
      logic        line_overflow;
   } rsp_word_type;

   // Per-cycle control broadcast to every matcher cell
   typedef struct packed {
      logic step;    // advance the chain with the current character
      logic clear;   // drop all partial matches
      logic load;    // latch a new keyword character (first word of a line)
   } cell_ctrl_type;

endpackage

### design/ksm_cell.sv
module ksm_cell #(
   parameter int CHAR_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ksm_pkg::cell_ctrl_type ctrl,
   input  logic [CHAR_BITS-1:0]   key_new,
   input  logic [CHAR_BITS-1:0]   char_in,
   input  logic                   enable,
   input  logic                   prev_act,
   output logic                   act,
   output logic                   hit
);
   import ksm_pkg::*;

   logic [CHAR_BITS-1:0] key_ff;
   logic [CHAR_BITS-1:0] key_in;
   logic                 act_ff;
   logic                 act_in;
   logic [CHAR_BITS-1:0] key_use;

   // on the opening word the fresh key char is compared directly
   assign key_use = ctrl.load ? key_new : key_ff;
   assign hit     = prev_act & enable & (char_in == key_use);
   assign key_in  = ctrl.load ? key_new : key_ff;

   always_comb begin
      act_in = act_ff;
      if (ctrl.clear) begin
         act_in = 1'b0;
      end else if (ctrl.step) begin
         act_in = hit;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
      if (reset) begin
         act_ff <= 1'b0;
      end else begin
         act_ff <= act_in;
      end
   end

   assign act = act_ff;

endmodule

### design/ksm_out_fifo.sv
module ksm_out_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push0,
   input  ksm_pkg::rsp_word_type push0_word,
   input  logic                  push1,
   input  ksm_pkg::rsp_word_type push1_word,
   output logic                  room_two,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output ksm_pkg::rsp_word_type rsp_word
);
   import ksm_pkg::*;

   localparam int DEPTH = 4;
   localparam int PTR_BITS = 2;

   rsp_word_type        entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS:0]   count_ff, count_in;
   logic                pop;
   logic [PTR_BITS:0]   n_push;
   logic [PTR_BITS-1:0] wr_ptr_p1;

   assign rsp_valid = (count_ff != '0);
   assign rsp_word  = entry_ff[rd_ptr_ff];
   assign pop       = rsp_valid & ~rsp_stall;
   assign room_two  = (count_ff <= (PTR_BITS+1)'(DEPTH - 2));
   assign wr_ptr_p1 = wr_ptr_ff + 1'b1;

   always_comb begin
      n_push = '0;
      if (push0 & push1) begin
         n_push = (PTR_BITS+1)'(2);
      end else if (push0) begin
         n_push = (PTR_BITS+1)'(1);
      end
      wr_ptr_in = wr_ptr_ff + n_push[PTR_BITS-1:0];
      rd_ptr_in = rd_ptr_ff + {{(PTR_BITS-1){1'b0}}, pop};
      count_in  = count_ff + n_push - {{PTR_BITS{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (push0) begin
         entry_ff[wr_ptr_ff] <= push0_word;
      end
      if (push1) begin
         entry_ff[wr_ptr_p1] <= push1_word;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/keyword_span_matcher.sv
// Channel   Ports                             Direction  Word
// --------  --------------------------------  ---------  -----------------------------
// request   req_valid, req_stall, req_word    in         one character / line end
// response  rsp_valid, rsp_stall, rsp_word    out        one span or bare end marker
// csr       csr_wr_en, csr_index, csr_wdata   in         key length and key characters
//
// A request word may cause zero, one or two response words,
// which go into a four-entry output queue. req_stall is raised while the queue has room
// for fewer than two words, so with an unstalled consumer one word per clock is sustained.
// The critical path is the cell compare plus the span start/adjoin add and compare.
// Reset is synchronous and active high; it clears the cells, line state, csr registers and
// the queue. No clearing pass is needed after reset.
// A stalled response holds its word; the request side keeps taking words until the queue
// is nearly full.
//
// Matching: a row of MAX_KEY cells, cell i holding keyword character i and a flag that the
// text since the last restart ends in key[0..i]. On each accepted character a flag moves
// one cell up when the incoming character equals that cell's key character. This tracks the
// same state as a KMP automaton, so a full match shows up as the flag of cell (length-1).
module keyword_span_matcher #(
   parameter int MAX_KEY   = 16,
   parameter int POS_BITS  = 16,
   parameter int CHAR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  ksm_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output ksm_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [ksm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ksm_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);
   import ksm_pkg::*;

   localparam int LEN_BITS = $clog2(MAX_KEY + 1);
   localparam int LW       = POS_BITS + 1;                 // position / length width
   localparam int SAT_BITS = (LW > FIELD_BITS + 1) ? LW : FIELD_BITS + 1;

   // csr registers
   logic [KEY_LEN_BITS-1:0]  key_length_ff;
   logic [CSR_DATA_BITS-1:0] key_chars_ff [KEY_REGS];

   // line state
   logic                line_open_ff, line_open_in;
   logic [LEN_BITS-1:0] line_len_ff, line_len_in;
   logic [LW-1:0]       pos_ff, pos_in;
   logic [LW-1:0]       pend_start_ff, pend_start_in;
   logic [LW-1:0]       pend_len_ff, pend_len_in;
   logic [LW-1:0]       pend_end_ff, pend_end_in;
   logic                pend_valid_ff, pend_valid_in;
   logic                ovf_ff, ovf_in;

   logic                room_two;
   logic                acc, active, opening, present, at_end, saturated, searching;
   logic [LEN_BITS-1:0] key_len_sat, eff_len;
   logic [LW-1:0]       len_pos, start_pos;
   logic [MAX_KEY-1:0]  en_vec, last_sel, act_vec, hit_vec;
   logic                match, adjoin, emit_old;
   cell_ctrl_type       ctrl;
   logic                push0, push1;
   rsp_word_type        old_word, end_word, push0_word;

   function automatic logic [FIELD_BITS-1:0] sat_len(input logic [LW-1:0] len);
      logic [SAT_BITS-1:0] ext;
      ext = SAT_BITS'(len);
      sat_len = (ext > SAT_BITS'({FIELD_BITS{1'b1}})) ? {FIELD_BITS{1'b1}}
                                                      : ext[FIELD_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] low_start(input logic [LW-1:0] pos);
      logic [SAT_BITS-1:0] ext;
      ext = SAT_BITS'(pos);
      low_start = ext[FIELD_BITS-1:0];
   endfunction

   // ---------------- csr writes ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= '0;
         for (int r = 0; r < KEY_REGS; r++) begin
            key_chars_ff[r] <= '0;
         end
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_KEY_LENGTH:  key_length_ff   <= csr_wdata[KEY_LEN_BITS-1:0];
            REG_KEY_CHARS_0: key_chars_ff[0] <= csr_wdata;
            REG_KEY_CHARS_1: key_chars_ff[1] <= csr_wdata;
            REG_KEY_CHARS_2: key_chars_ff[2] <= csr_wdata;
            REG_KEY_CHARS_3: key_chars_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- request decode ----------------
   assign req_stall = ~room_two;
   assign acc       = req_valid & ~req_stall;
   assign present   = req_word.char_present;
   assign at_end    = req_word.line_end;
   assign active    = acc & (present | at_end);   // neither flag: word is dropped
   assign opening   = ~line_open_ff;
   assign saturated = pos_ff[POS_BITS];

   // keyword latched for the line on its first word; csr changes apply next line
   assign key_len_sat = (key_length_ff > KEY_LEN_BITS'(MAX_KEY)) ? LEN_BITS'(MAX_KEY)
                                                                 : key_length_ff[LEN_BITS-1:0];
   assign eff_len   = opening ? key_len_sat : line_len_ff;
   assign searching = active & present & ~saturated & (eff_len != '0);

   always_comb begin
      for (int i = 0; i < MAX_KEY; i++) begin
         en_vec[i]   = (LEN_BITS'(i) < eff_len);
         last_sel[i] = (LEN_BITS'(i + 1) == eff_len);
      end
   end

   assign ctrl.load  = active & opening;
   assign ctrl.step  = searching;
   assign ctrl.clear = active & (match | at_end | (present & saturated));

   // ---------------- cell row ----------------
   for (genvar g = 0; g < MAX_KEY; g++) begin : g_cell
      ksm_cell #(
         .CHAR_BITS (CHAR_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .key_new  (key_chars_ff[g / SLOTS_PER_REG]
                                [(g % SLOTS_PER_REG) * SLOT_BITS +: CHAR_BITS]),
         .char_in  (req_word.char_code[CHAR_BITS-1:0]),
         .enable   (en_vec[g]),
         .prev_act ((g == 0) ? 1'b1 : act_vec[(g == 0) ? 0 : g - 1]),
         .act      (act_vec[g]),
         .hit      (hit_vec[g])
      );
   end

   assign match = searching & |(hit_vec & last_sel);

   // ---------------- span tracking ----------------
   assign len_pos   = LW'(eff_len);
   assign start_pos = pos_ff + LW'(1) - len_pos;
   assign adjoin    = pend_valid_ff & (start_pos == pend_end_ff);
   assign emit_old  = match & ~adjoin & pend_valid_ff;

   always_comb begin
      line_open_in  = line_open_ff;
      line_len_in   = line_len_ff;
      pos_in        = pos_ff;
      pend_start_in = pend_start_ff;
      pend_len_in   = pend_len_ff;
      pend_end_in   = pend_end_ff;
      pend_valid_in = pend_valid_ff;
      ovf_in        = ovf_ff;

      if (active) begin
         line_open_in = 1'b1;
         line_len_in  = eff_len;
         if (present) begin
            if (saturated) begin
               ovf_in = 1'b1;
            end else begin
               pos_in = pos_ff + LW'(1);
            end
         end
         if (match) begin
            if (adjoin) begin
               pend_len_in = pend_len_ff + len_pos;
               pend_end_in = pend_end_ff + len_pos;
            end else begin
               pend_start_in = start_pos;
               pend_len_in   = len_pos;
               pend_end_in   = pos_ff + LW'(1);
               pend_valid_in = 1'b1;
            end
         end
      end
   end

   // results: the replaced span, then the line's closing word
   always_comb begin
      old_word               = '0;
      old_word.span_start    = low_start(pend_start_ff);
      old_word.span_length   = sat_len(pend_len_ff);
      old_word.span_present  = 1'b1;

      end_word               = '0;
      end_word.last_of_line  = 1'b1;
      end_word.line_overflow = ovf_in;
      if (pend_valid_in) begin
         end_word.span_start   = low_start(pend_start_in);
         end_word.span_length  = sat_len(pend_len_in);
         end_word.span_present = 1'b1;
      end
   end

   assign push0      = active & (emit_old | at_end);
   assign push1      = active & emit_old & at_end;
   assign push0_word = emit_old ? old_word : end_word;

   always_ff @(posedge clock) begin
      pend_start_ff <= pend_start_in;
      pend_len_ff   <= pend_len_in;
      pend_end_ff   <= pend_end_in;
      line_len_ff   <= line_len_in;
      if (reset) begin
         line_open_ff  <= 1'b0;
         pos_ff        <= '0;
         pend_valid_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else if (active & at_end) begin
         line_open_ff  <= 1'b0;
         pos_ff        <= '0;
         pend_valid_ff <= 1'b0;
         ovf_ff        <= 1'b0;
      end else begin
         line_open_ff  <= line_open_in;
         pos_ff        <= pos_in;
         pend_valid_ff <= pend_valid_in;
         ovf_ff        <= ovf_in;
      end
   end

   // ---------------- output queue ----------------
   ksm_out_fifo u_out_fifo (
      .clock      (clock),
      .reset      (reset),
      .push0      (push0),
      .push0_word (push0_word),
      .push1      (push1),
      .push1_word (end_word),
      .room_two   (room_two),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word)
   );

endmodule

### design/ksm_checker.sv
module ksm_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input ksm_pkg::rsp_word_type rsp_word
);
   import ksm_pkg::*;

   // stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("response word changed while stalled");

   // queue comes out of reset empty and open
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("queue not empty after reset");

   // bare end marker carries no span and closes the line
   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.span_present |->
         rsp_word.last_of_line && rsp_word.span_start == '0 && rsp_word.span_length == '0)
      else $error("malformed end marker");

   // mid-line words are real spans without overflow flag
   a_mid_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last_of_line |->
         rsp_word.span_present && !rsp_word.line_overflow && rsp_word.span_length != '0)
      else $error("malformed mid-line span");

endmodule

bind keyword_span_matcher ksm_checker u_ksm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

### test/ksm_span_monitor.sv
module ksm_span_monitor #(
   parameter int MAX_KEY   = 16,
   parameter int POS_BITS  = 16,
   parameter int CHAR_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  ksm_pkg::req_word_type                req_word,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  ksm_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_wr_en,
   input  logic [ksm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [ksm_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   output int                                   mismatches,
   output int                                   outstanding,
   output int                                   responses,
   output int                                   spans,
   output int                                   overflowed
);
   timeunit 1ns;
   timeprecision 1ps;

   import ksm_pkg::*;

   localparam longint POS_LIMIT = longint'(1) << POS_BITS;
   localparam logic [15:0] CHAR_MASK = 16'((32'd1 << CHAR_BITS) - 1);
   localparam int PRINT_CAP = 40;

   // register copies
   logic [4:0]  key_len_reg;
   logic [63:0] key_regs [4];

   // line state, keyword latched when a line opens
   bit          line_open;
   int          key_n;
   logic [15:0] line_key [16];
   int          fall_back [16];
   int          progress;
   longint      line_pos;
   longint      span_at;
   longint      span_len;
   bit          span_held;
   bit          overflow_seen;

   rsp_word_type due_words [$];
   rsp_word_type want;

   int err_count  = 0;
   int resp_count = 0;
   int span_count = 0;
   int ovf_count  = 0;

   task automatic report_mismatch(string msg);
      err_count++;
      // keep the log short on a badly broken design, count everything
      if (err_count <= PRINT_CAP) $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic compare_field(string name, int got, int wanted);
      if (got != wanted)
         report_mismatch($sformatf("%s got %0d, wanted %0d", name, got, wanted));
   endtask

   function automatic void queue_word(longint at, longint len, bit present, bit last, bit ovf);
      rsp_word_type w;
      w.span_start    = at[15:0];
      w.span_length   = (len > 64'hFFFF) ? 16'hFFFF : len[15:0];
      w.span_present  = present;
      w.last_of_line  = last;
      w.line_overflow = ovf;
      due_words.push_back(w);
   endfunction

   function automatic void clear_line();
      progress      = 0;
      line_pos      = 0;
      span_at       = 0;
      span_len      = 0;
      span_held     = 0;
      overflow_seen = 0;
      line_open     = 0;
   endfunction

   // latch the keyword and build the optimized failure table
   function automatic void start_line();
      int n, i, k;
      n = key_len_reg;
      if (n > MAX_KEY) n = MAX_KEY;
      if (n > 16) n = 16;
      key_n = n;
      for (i = 0; i < 16; i++) begin
         line_key[i]  = key_regs[i / 4][(i % 4) * 16 +: 16] & CHAR_MASK;
         fall_back[i] = 0;
      end
      if (n > 0) begin
         fall_back[0] = -1;
         i = 0;
         k = -1;
         while (i + 1 < n) begin
            if (k < 0 || line_key[i] == line_key[k]) begin
               i++;
               k++;
               if (line_key[i] != line_key[k]) fall_back[i] = k;
               else fall_back[i] = fall_back[k];
            end else begin
               k = fall_back[k];
            end
         end
      end
      progress  = 0;
      line_open = 1;
   endfunction

   function automatic void scan_word(req_word_type w);
      logic [15:0] c;
      longint p, at;
      int j;
      bit searching;
      c = w.char_code & CHAR_MASK;
      if (!w.char_present && !w.line_end) return;
      if (!line_open) start_line();

      if (w.char_present) begin
         if (line_pos >= POS_LIMIT) begin
            overflow_seen = 1;
            progress      = 0;
         end else begin
            p = line_pos;
            line_pos++;
            if (key_n > 0) begin
               j = progress;
               if (j >= key_n) j = 0;
               searching = 1;
               while (searching) begin
                  if (line_key[j] == c) begin
                     j++;
                     searching = 0;
                  end else if (fall_back[j] < 0) begin
                     j = 0;
                     searching = 0;
                  end else begin
                     j = fall_back[j];
                  end
               end
               if (j >= key_n) begin
                  at = p + 1 - key_n;
                  j  = 0;
                  if (span_held && at == span_at + span_len) begin
                     span_len += key_n;
                  end else begin
                     if (span_held) queue_word(span_at, span_len, 1, 0, 0);
                     span_at   = at;
                     span_len  = key_n;
                     span_held = 1;
                  end
               end
               progress = j;
            end
         end
      end

      if (w.line_end) begin
         if (span_held) queue_word(span_at, span_len, 1, 1, overflow_seen);
         else queue_word(0, 0, 0, 1, overflow_seen);
         clear_line();
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_len_reg = '0;
         for (int r = 0; r < 4; r++) key_regs[r] = '0;
         key_n = 0;
         for (int s = 0; s < 16; s++) begin
            line_key[s]  = '0;
            fall_back[s] = 0;
         end
         clear_line();
         due_words.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_KEY_LENGTH:  key_len_reg = csr_wdata[KEY_LEN_BITS-1:0];
               REG_KEY_CHARS_0: key_regs[0] = csr_wdata;
               REG_KEY_CHARS_1: key_regs[1] = csr_wdata;
               REG_KEY_CHARS_2: key_regs[2] = csr_wdata;
               REG_KEY_CHARS_3: key_regs[3] = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) scan_word(req_word);
         if (rsp_valid && !rsp_stall) begin
            if (due_words.size() == 0) begin
               report_mismatch($sformatf("response word %h with nothing due", rsp_word));
            end else begin
               want = due_words.pop_front();
               resp_count++;
               if (want.span_present) span_count++;
               if (want.last_of_line && want.line_overflow) ovf_count++;
               compare_field("span_start", rsp_word.span_start, want.span_start);
               compare_field("span_length", rsp_word.span_length, want.span_length);
               compare_field("span_present", rsp_word.span_present, want.span_present);
               compare_field("last_of_line", rsp_word.last_of_line, want.last_of_line);
               compare_field("line_overflow", rsp_word.line_overflow, want.line_overflow);
            end
         end
      end
      outstanding <= due_words.size();
      mismatches  <= err_count;
      responses   <= resp_count;
      spans       <= span_count;
      overflowed  <= ovf_count;
   end

endmodule

### test/keyword_span_matcher_tb.sv
module keyword_span_matcher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ksm_pkg::*;

   localparam int IDLE_LIMIT    = 2000;   // cycles with no handshake on either channel
   localparam int RANDOM_ITEMS  = 1550;
   localparam int SETTLE_CYCLES = 8;      // drain time for words that produce nothing

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_mode_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   req_word_type              req_word  = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   rsp_word_type              rsp_word;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   int mismatches, outstanding, responses, spans, overflowed;

   // sender bookkeeping
   bit gaps_on       = 1'b1;
   int burst_left    = 0;
   int words_sent    = 0;
   int ignored_sent  = 0;
   int lines_sent    = 0;
   int settings_used = 0;

   // current text alphabet and keyword as the stimulus sees them
   logic [15:0] alpha [4];
   int          alpha_n = 1;
   logic [15:0] key_buf [16];
   int          eff_len = 0;
   logic [15:0] line_text [$];

   // receiver pattern
   stall_mode_type stall_mode = STALL_NONE;
   int             mode_left  = 0;
   int             run_left   = 0;
   int             stuck      = 0;

   always #5 clock = ~clock;

   keyword_span_matcher uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   ksm_span_monitor span_mon (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .responses   (responses),
      .spans       (spans),
      .overflowed  (overflowed)
   );

   // Receiver: a mode is held for a random stretch, modes range from never stalling
   // through sparse stalls and long on/off runs to mostly stalled.
   always @(posedge clock) begin
      if (mode_left == 0) begin
         stall_mode <= stall_mode_type'($urandom_range(0, 3));
         mode_left  <= $urandom_range(40, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_RUNS: begin
            if (run_left == 0) begin
               rsp_stall <= !rsp_stall;
               run_left  <= $urandom_range(1, 20);
            end else begin
               run_left <= run_left - 1;
            end
         end
         default:     rsp_stall <= ($urandom_range(0, 3) != 0);
      endcase
   end

   // Watchdog: any handshake on either channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck <= 0;
      end else if (stuck >= IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d responses due",
                  stuck, outstanding);
         $display("tb: failure");
         $finish;
      end else begin
         stuck <= stuck + 1;
      end
   end

   // One request word. Bursts of random length, random gaps in between; valid is
   // only dropped in a gap or by quiesce, never between two back-to-back words.
   task automatic put_word(logic [15:0] code, bit present, bit last);
      int gap;
      if (gaps_on && burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      if (burst_left > 0) burst_left--;
      req_word  <= '{char_code: code, char_present: present, line_end: last};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (present || last) words_sent++;
      else ignored_sent++;
      if (last) lines_sent++;
   endtask

   // Hold off until every due response is back, then give words that make no
   // response time to leave the pipe.
   task automatic quiesce();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   // Writes all five registers from key_buf. Upper bits of the length word carry junk,
   // only the low five count.
   task automatic load_key(int len);
      logic [CSR_DATA_BITS-1:0] junk;
      quiesce();
      junk = {$urandom, $urandom};
      junk[KEY_LEN_BITS-1:0] = len[KEY_LEN_BITS-1:0];
      write_reg(REG_KEY_LENGTH, junk);
      write_reg(REG_KEY_CHARS_0, {key_buf[3], key_buf[2], key_buf[1], key_buf[0]});
      write_reg(REG_KEY_CHARS_1, {key_buf[7], key_buf[6], key_buf[5], key_buf[4]});
      write_reg(REG_KEY_CHARS_2, {key_buf[11], key_buf[10], key_buf[9], key_buf[8]});
      write_reg(REG_KEY_CHARS_3, {key_buf[15], key_buf[14], key_buf[13], key_buf[12]});
      eff_len = (len > 16) ? 16 : len;
      settings_used++;
   endtask

   function automatic logic [15:0] pick_symbol();
      return alpha[$urandom_range(0, alpha_n - 1)];
   endfunction

   // Key lengths: off, one, full, above the maximum (saturates), or short.
   task automatic pick_key();
      int len;
      case ($urandom_range(0, 7))
         0:       len = 0;
         1:       len = 1;
         2:       len = 16;
         3:       len = $urandom_range(17, 31);
         default: len = $urandom_range(2, 8);
      endcase
      for (int s = 0; s < 16; s++)
         key_buf[s] = ($urandom_range(0, 7) == 0) ? 16'($urandom) : pick_symbol();
      load_key(len);
   endtask

   initial begin
      int i, k, target, seg, m, mid, n_lines, base;
      bit bare_end;
      logic [15:0] a, b, x;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // ---- directed words ----
      // key length is zero out of reset: the line just ends with a bare marker
      put_word(16'h1234, 1'b1, 1'b0);
      put_word(16'h5678, 1'b1, 1'b1);
      // no character and no end: ignored
      put_word(16'hFFFF, 1'b0, 1'b0);
      // empty line, end word only
      put_word(16'hAAAA, 1'b0, 1'b1);

      // two-character key at the code extremes
      a = 16'h0000;
      b = 16'hFFFF;
      x = 16'h8001;
      key_buf[0] = a;
      key_buf[1] = b;
      for (i = 2; i < 16; i++) key_buf[i] = 16'($urandom);
      load_key(2);
      // matches at 0 and 2 adjoin into one span; the match at 5 completes on the
      // end word and does not adjoin, so that word yields two responses
      put_word(a, 1'b1, 1'b0);
      put_word(b, 1'b1, 1'b0);
      put_word(a, 1'b1, 1'b0);
      put_word(b, 1'b1, 1'b0);
      put_word(x, 1'b1, 1'b0);
      put_word(a, 1'b1, 1'b0);
      put_word(b, 1'b1, 1'b1);

      // key rewritten mid-line: the open line keeps the old key
      put_word(a, 1'b1, 1'b0);
      key_buf[0] = x;
      load_key(1);
      put_word(x, 1'b1, 1'b0);
      put_word(a, 1'b1, 1'b0);
      put_word(b, 1'b1, 1'b1);
      // next line sees the new one-character key
      put_word(x, 1'b1, 1'b1);
      // line closed by an end word without a character
      put_word(x, 1'b1, 1'b0);
      put_word(x, 1'b1, 1'b0);
      put_word(16'h5555, 1'b0, 1'b1);

      // ---- random phases: new alphabet and key, a few lines each ----
      base = words_sent;
      while (words_sent - base < RANDOM_ITEMS) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         alpha_n = $urandom_range(1, 4);
         for (i = 0; i < 4; i++) begin
            case ($urandom_range(0, 5))
               0:       alpha[i] = 16'h0000;
               1:       alpha[i] = 16'hFFFF;
               default: alpha[i] = 16'($urandom);
            endcase
         end
         pick_key();
         n_lines = $urandom_range(2, 8);
         repeat (n_lines) begin
            // text mostly made of whole keys, key prefixes and alphabet symbols,
            // so that KMP fall-backs and adjoining matches show up often
            line_text.delete();
            target = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 40);
            while (line_text.size() < target) begin
               seg = $urandom_range(0, 9);
               if (eff_len > 0 && seg < 4) begin
                  for (k = 0; k < eff_len; k++) line_text.push_back(key_buf[k]);
               end else if (eff_len > 1 && seg < 6) begin
                  m = $urandom_range(1, eff_len - 1);
                  for (k = 0; k < m; k++) line_text.push_back(key_buf[k]);
               end else if (seg == 9) begin
                  line_text.push_back(16'($urandom));
               end else begin
                  line_text.push_back(pick_symbol());
               end
            end
            mid = ($urandom_range(0, 11) == 0 && line_text.size() >= 2) ?
                  $urandom_range(1, line_text.size() - 1) : -1;
            bare_end = (line_text.size() == 0) || ($urandom_range(0, 4) == 0);
            // now and then wait for every response before the next line
            if ($urandom_range(0, 9) == 0) quiesce();
            for (i = 0; i < line_text.size(); i++) begin
               if (i == mid) pick_key();
               if ($urandom_range(0, 15) == 0) put_word(16'($urandom), 1'b0, 1'b0);
               put_word(line_text[i], 1'b1, !bare_end && i == line_text.size() - 1);
            end
            if (bare_end) put_word(16'($urandom), 1'b0, 1'b1);
         end
      end

      // ---- drain and verdict ----
      quiesce();
      repeat (20) @(posedge clock);
      $display("summary: %0d words in %0d lines (%0d ignored words), %0d key settings",
               words_sent, lines_sent, ignored_sent, settings_used);
      $display("summary: %0d responses checked, %0d spans, %0d lines past the limit",
               responses, spans, overflowed);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("tb: failure");
      end
      $finish;
   end

endmodule
